// ===== rtl/lkv_pkg.sv =====
// Shared types and constants for the LRU key/value store.
// No dependencies; used by lkv_cfg, lkv_cell and lru_key_value_store.
package lkv_pkg;

    localparam int CAP_BITS  = 4;
    localparam int ADDR_BITS = 1;
    localparam int DATA_BITS = 32;

    localparam logic [CAP_BITS-1:0]  CAP_RESET    = 4'd8;
    localparam logic [ADDR_BITS-1:0] REG_CAPACITY = 1'b0;

    typedef enum logic [0:0] {
        OP_LOOKUP = 1'b0,
        OP_STORE  = 1'b1
    } t_opcode;

    // Broadcast from the top level to every cell for one transaction.
    typedef struct packed {
        logic fire;   // transaction accepted this cycle
        logic store;  // store, else lookup
        logic hit;    // key found in some cell
    } t_cell_ctrl;

endpackage

// ===== rtl/lkv_cfg.sv =====
// APB-style configuration register block: holds capacity_in_use.
// Depends on lkv_pkg.
module lkv_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lkv_pkg::ADDR_BITS-1:0] paddr,
    input  logic [lkv_pkg::DATA_BITS-1:0] pwdata,
    output logic [lkv_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    output logic [lkv_pkg::CAP_BITS-1:0]  o_capacity
);

    logic [lkv_pkg::CAP_BITS-1:0] r_capacity;
    logic                         w_write;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite && (paddr == lkv_pkg::REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lkv_pkg::CAP_RESET;
        end else if (w_write) begin
            r_capacity <= pwdata[lkv_pkg::CAP_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == lkv_pkg::REG_CAPACITY) begin
            prdata = {{(lkv_pkg::DATA_BITS - lkv_pkg::CAP_BITS){1'b0}}, r_capacity};
        end
    end

    assign o_capacity = r_capacity;

endmodule

// ===== rtl/lkv_cell.sv =====
// One entry of the recency-ordered chain: key, value and valid mark.
// Loads from its left neighbor when the chain shifts. Depends on lkv_pkg.
module lkv_cell #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int CNT_W      = 4,
    parameter int INDEX      = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lkv_pkg::t_cell_ctrl    i_ctrl,
    input  logic [CNT_W-1:0]       i_limit,
    input  logic [KEY_BITS-1:0]    i_key,
    input  logic [KEY_BITS-1:0]    i_prev_key,
    input  logic [VALUE_BITS-1:0]  i_prev_value,
    input  logic                   i_prev_valid,
    input  logic                   i_match_right,
    output logic [KEY_BITS-1:0]    o_key,
    output logic [VALUE_BITS-1:0]  o_value,
    output logic                   o_valid,
    output logic                   o_match_chain,
    output logic [VALUE_BITS-1:0]  o_hit_value
);

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_valid;
    logic                  w_match;
    logic                  w_shift;

    assign w_match       = r_valid && (r_key == i_key);
    // some cell at this position or further along matches
    assign o_match_chain = w_match || i_match_right;
    assign o_hit_value   = w_match ? r_value : '0;

    always_comb begin
        w_shift = 1'b0;
        if (i_ctrl.fire) begin
            if (i_ctrl.hit) begin
                w_shift = o_match_chain;
            end else if (i_ctrl.store) begin
                w_shift = (i_limit >= CNT_W'(INDEX));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_shift) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_key   <= i_prev_key;
            r_value <= i_prev_value;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

// ===== rtl/lru_key_value_store.sv =====
// Top level of the fully associative LRU key/value store.
// Depends on lkv_pkg, lkv_cfg and lkv_cell.
//
//  channel   direction  handshake            payload
//  request   in         i_valid / o_ready    i_opcode, i_lookup_key, i_write_value
//  result    out        o_valid / i_ready    o_hit, o_read_value, o_evicted
//  config    in         psel/penable/pready  paddr, pwdata, pwrite, prdata
//
// One transaction per cycle: the cells compare the key in parallel and the
// chain shifts in the same cycle, so the result register holds the answer
// in the cycle after acceptance. Cell 0 is most recent, so eviction drops the
// cell at position count-1. A stalled result stops intake only while the
// result register is full and not taken. Synchronous reset clears the valid
// marks, the count and the result valid flag; capacity returns to 8.
module lru_key_value_store #(
    parameter int ENTRIES    = 8,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_opcode,
    input  logic signed [KEY_BITS-1:0]    i_lookup_key,
    input  logic signed [VALUE_BITS-1:0]  i_write_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    output logic signed [VALUE_BITS-1:0]  o_read_value,
    output logic                          o_evicted,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lkv_pkg::ADDR_BITS-1:0] paddr,
    input  logic [lkv_pkg::DATA_BITS-1:0] pwdata,
    output logic [lkv_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [lkv_pkg::CAP_BITS-1:0] w_capacity;
    logic [CNT_W-1:0]             w_cap_eff;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic [CNT_W-1:0]             w_limit;

    logic                         w_fire;
    logic                         w_store;
    logic                         w_hit;
    logic                         w_evict;
    logic [VALUE_BITS-1:0]        w_hit_value;
    logic [VALUE_BITS-1:0]        w_new_value;
    lkv_pkg::t_cell_ctrl          w_ctrl;

    logic [KEY_BITS-1:0]          w_key       [ENTRIES];
    logic [VALUE_BITS-1:0]        w_value     [ENTRIES];
    logic [VALUE_BITS-1:0]        w_cell_hit  [ENTRIES];
    logic [ENTRIES-1:0]           w_valid;
    logic [ENTRIES-1:0]           w_chain;

    logic                         r_out_valid;
    logic                         r_hit;
    logic [VALUE_BITS-1:0]        r_read_value;
    logic                         r_evicted;

    lkv_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (w_capacity)
    );

    // clamp capacity into 1..ENTRIES
    always_comb begin
        if (w_capacity == '0) begin
            w_cap_eff = CNT_W'(1);
        end else if (32'(w_capacity) > ENTRIES) begin
            w_cap_eff = CNT_W'(ENTRIES);
        end else begin
            w_cap_eff = CNT_W'(w_capacity);
        end
    end

    // refuse requests while reset is held
    assign o_ready = i_rst_n && (!r_out_valid || i_ready);
    assign w_fire  = i_valid && o_ready;
    assign w_store = (lkv_pkg::t_opcode'(i_opcode) == lkv_pkg::OP_STORE);
    assign w_hit   = w_chain[0];
    assign w_evict = w_store && !w_hit && (r_count >= w_cap_eff);
    // last position that takes its neighbor on an insert
    assign w_limit = r_count - CNT_W'(w_evict);

    always_comb begin
        w_hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_hit_value = w_hit_value | w_cell_hit[i];
        end
    end

    assign w_new_value = w_store ? i_write_value : w_hit_value;

    assign w_ctrl.fire  = w_fire;
    assign w_ctrl.store = w_store;
    assign w_ctrl.hit   = w_hit;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic [KEY_BITS-1:0]   w_pkey;
        logic [VALUE_BITS-1:0] w_pvalue;
        logic                  w_pvalid;
        logic                  w_right;

        if (g == 0) begin : g_head
            assign w_pkey   = i_lookup_key;
            assign w_pvalue = w_new_value;
            assign w_pvalid = 1'b1;
        end else begin : g_body
            assign w_pkey   = w_key[g-1];
            assign w_pvalue = w_value[g-1];
            assign w_pvalid = w_valid[g-1];
        end

        if (g == ENTRIES - 1) begin : g_tail
            assign w_right = 1'b0;
        end else begin : g_inner
            assign w_right = w_chain[g+1];
        end

        lkv_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .CNT_W      (CNT_W),
            .INDEX      (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_limit       (w_limit),
            .i_key         (i_lookup_key),
            .i_prev_key    (w_pkey),
            .i_prev_value  (w_pvalue),
            .i_prev_valid  (w_pvalid),
            .i_match_right (w_right),
            .o_key         (w_key[g]),
            .o_value       (w_value[g]),
            .o_valid       (w_valid[g]),
            .o_match_chain (w_chain[g]),
            .o_hit_value   (w_cell_hit[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_fire && w_store && !w_hit && !w_evict) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_hit        <= w_hit;
            r_read_value <= (!w_store && w_hit) ? w_hit_value : '0;
            r_evicted    <= w_evict;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hit        = r_hit;
    assign o_read_value = r_read_value;
    assign o_evicted    = r_evicted;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= ENTRIES)
        else $error("entry count above ENTRIES");

    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == 32'(r_count))
        else $error("valid marks disagree with entry count");

    a_store_lands_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_store) |=> (w_valid[0] && w_key[0] == $past(i_lookup_key)
                                 && w_value[0] == $past(i_write_value)))
        else $error("stored pair not most recent");

    a_no_evict_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_evict) |-> (!w_hit && r_count != '0))
        else $error("eviction on hit or empty store");

endmodule
